FILE: rtl/core/tce_pkg.sv
// Shared types, constants and codes of the text console engine.
package tce_pkg;

  // Screen geometry.
  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELLS         = SCREEN_WIDTH * SCREEN_HEIGHT;

  // Field and storage widths.
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int HW_W    = 12;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int RAM_W   = 16;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character and attribute constants.
  localparam logic [7:0] BLANK_CHAR  = 8'h20;
  localparam logic [7:0] BLANK_COLOR = 8'h07;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_BS       = 8'h08;

  // Register map of the configuration port.
  localparam int          APB_AW          = 3;
  localparam logic [2:0]  REG_TEXT_COLOR  = 3'd0;
  // Register index as decoded from the word address bits of paddr.
  localparam logic [APB_AW-3:0] REG_IDX_TEXT_COLOR = '0;
  localparam logic [7:0]  TEXT_COLOR_RST  = 8'h07;

  // Command codes on the input port.
  localparam logic [2:0] ACT_PUT     = 3'd0;
  localparam logic [2:0] ACT_DRAW    = 3'd1;
  localparam logic [2:0] ACT_SETCUR  = 3'd2;
  localparam logic [2:0] ACT_READ    = 3'd3;
  localparam logic [2:0] ACT_HIDE    = 3'd4;
  localparam logic [2:0] ACT_SHOW    = 3'd5;
  localparam logic [2:0] ACT_CLEAR   = 3'd6;

  // Classified operations handed from the front to the back.
  typedef enum logic [3:0] {
    OP_NEWLINE,
    OP_CR,
    OP_BS,
    OP_PRINT,
    OP_DRAW,
    OP_SETCUR,
    OP_READ,
    OP_HIDE,
    OP_SHOW,
    OP_CLEAR,
    OP_OOB,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_WIPE,
    ST_FIN
  } back_state_e;

  typedef struct packed {
    logic [2:0]       action;
    logic [7:0]       byte_value;
    logic [ROW_W-1:0] target_row;
    logic [COL_W-1:0] target_col;
    logic [7:0]       cell_color;
  } cmd_t;

  typedef struct packed {
    logic             status;
    logic [7:0]       read_char;
    logic [7:0]       echo_byte;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic             cursor_hidden;
    logic [HW_W-1:0]  hw_cursor;
  } result_t;

  typedef struct packed {
    op_e              op;
    logic [7:0]       byte_value;
    logic [ROW_W-1:0] target_row;
    logic [COL_W-1:0] target_col;
    logic [7:0]       cell_color;
  } q_entry_t;

endpackage

FILE: rtl/core/text_console_engine_core.sv
// Top level of the text console engine: configuration port, command front end and back end.
//
// A command is taken when start is high and busy is low; its result word is valid on
// result_o while done_o is high for exactly one cycle, in command order, and cannot be
// held off. After reset busy stays high while the screen store is blanked, one cell a
// cycle. The front end queues up to two commands, so busy falls again as soon as a queue
// slot frees. In the back end a cursor command, a put byte that does not scroll or a draw
// passes through the states IDLE, EXEC and FIN, and a cell read adds READ after EXEC for
// the registered read of the single-write screen store, which is touched once per command.
// A newline or printed character that scrolls the screen moves one cell per cycle in
// SCROLL and then blanks the bottom row in BLANK, and a clear blanks one cell per cycle.
module text_console_engine_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tce_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  tce_pkg::cmd_t                cmd_i,
  output logic                         done_o,
  output tce_pkg::result_t             result_o
);

  logic [7:0]        text_color_q;
  logic              cfg_sel;
  logic              cfg_write;
  logic              q_valid;
  tce_pkg::q_entry_t q_entry;
  logic              pop;
  logic              hold;

  // Registers are decoded by word; the byte offset bits are ignored.
  assign cfg_sel   = (paddr[tce_pkg::APB_AW-1:2] == tce_pkg::REG_IDX_TEXT_COLOR);
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & cfg_sel;
  assign prdata    = cfg_sel ? {24'h000000, text_color_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= tce_pkg::TEXT_COLOR_RST;
    end else if (cfg_write) begin
      text_color_q <= pwdata[7:0];
    end
  end

  tce_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .cmd_i     (cmd_i),
    .hold_i    (hold),
    .pop_i     (pop),
    .q_valid_o (q_valid),
    .q_entry_o (q_entry)
  );

  tce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_color_i (text_color_q),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_entry),
    .pop_o        (pop),
    .hold_o       (hold),
    .done_o       (done_o),
    .result_o     (result_o)
  );

endmodule

FILE: rtl/core/tce_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tce_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tce_front.sv
// Command front end: accepts commands, classifies them and queues them for the back end.
module tce_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tce_pkg::cmd_t     cmd_i,
  input  logic              hold_i,
  input  logic              pop_i,
  output logic              q_valid_o,
  output tce_pkg::q_entry_t q_entry_o
);

  localparam int RW = tce_pkg::ROW_W;
  localparam int CW = tce_pkg::COL_W;
  localparam int PW = tce_pkg::QPTR_W;
  localparam int NW = tce_pkg::QCNT_W;
  localparam logic [RW:0] HLIM = (RW + 1)'(tce_pkg::SCREEN_HEIGHT);
  localparam logic [CW:0] WLIM = (CW + 1)'(tce_pkg::SCREEN_WIDTH);
  localparam logic [NW-1:0] QFULL = NW'(tce_pkg::QUEUE_DEPTH);
  localparam logic [PW-1:0] QLAST = PW'(tce_pkg::QUEUE_DEPTH - 1);

  tce_pkg::q_entry_t fifo_q [tce_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]     count_q, count_d;
  logic              full;
  logic              push;
  logic              pop;
  logic              target_ok;
  tce_pkg::op_e      op;
  tce_pkg::q_entry_t entry;

  assign full      = (count_q == QFULL);
  assign busy      = full | hold_i;
  assign push      = start & ~busy;
  assign q_valid_o = (count_q != '0);
  assign pop       = pop_i & q_valid_o;
  assign q_entry_o = fifo_q[rd_ptr_q];

  assign target_ok = ({1'b0, cmd_i.target_row} < HLIM) && ({1'b0, cmd_i.target_col} < WLIM);

  always_comb begin
    unique case (cmd_i.action)
      tce_pkg::ACT_PUT: begin
        if (cmd_i.byte_value == tce_pkg::CH_NL) begin
          op = tce_pkg::OP_NEWLINE;
        end else if (cmd_i.byte_value == tce_pkg::CH_CR) begin
          op = tce_pkg::OP_CR;
        end else if (cmd_i.byte_value == tce_pkg::CH_BS) begin
          op = tce_pkg::OP_BS;
        end else begin
          op = tce_pkg::OP_PRINT;
        end
      end
      tce_pkg::ACT_DRAW:   op = target_ok ? tce_pkg::OP_DRAW : tce_pkg::OP_OOB;
      tce_pkg::ACT_SETCUR: op = target_ok ? tce_pkg::OP_SETCUR : tce_pkg::OP_OOB;
      tce_pkg::ACT_READ:   op = target_ok ? tce_pkg::OP_READ : tce_pkg::OP_OOB;
      tce_pkg::ACT_HIDE:   op = tce_pkg::OP_HIDE;
      tce_pkg::ACT_SHOW:   op = tce_pkg::OP_SHOW;
      tce_pkg::ACT_CLEAR:  op = tce_pkg::OP_CLEAR;
      default:             op = tce_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    entry.op         = op;
    entry.byte_value = cmd_i.byte_value;
    entry.target_row = cmd_i.target_row;
    entry.target_col = cmd_i.target_col;
    entry.cell_color = cmd_i.cell_color;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QLAST) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QLAST) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + NW'(1);
    end else if (pop && !push) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

  // The queue never holds more words than it has slots.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QFULL)
    else $error("command queue count out of range");

  // A word taken into an empty queue must not be lost: the queue then offers it to the back end.
  a_empty_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && count_q == '0) |=> q_valid_o)
    else $error("queued word lost");

endmodule

FILE: rtl/core/tce_back.sv
// Command back end: cursor state, screen store and the sequences that carry out each command.
module tce_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        text_color_i,
  input  logic              q_valid_i,
  input  tce_pkg::q_entry_t q_entry_i,
  output logic              pop_o,
  output logic              hold_o,
  output logic              done_o,
  output tce_pkg::result_t  result_o
);

  localparam int RW = tce_pkg::ROW_W;
  localparam int CW = tce_pkg::COL_W;
  localparam int AW = tce_pkg::ADDR_W;
  localparam int NW = tce_pkg::CNT_W;
  localparam int HW = tce_pkg::HW_W;
  localparam int DW = tce_pkg::RAM_W;
  localparam logic [RW-1:0] LAST_ROW  = RW'(tce_pkg::SCREEN_HEIGHT - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(tce_pkg::SCREEN_WIDTH - 1);
  localparam logic [NW-1:0] CELL_CNT  = NW'(tce_pkg::CELLS);
  localparam logic [NW-1:0] CELL_LAST = NW'(tce_pkg::CELLS - 1);
  localparam logic [NW-1:0] ROW1_BASE = NW'(tce_pkg::SCREEN_WIDTH);
  localparam logic [NW-1:0] LROW_BASE = NW'(tce_pkg::CELLS - tce_pkg::SCREEN_WIDTH);
  localparam logic [AW-1:0] ROW_SPAN  = AW'(tce_pkg::SCREEN_WIDTH);
  localparam logic [DW-1:0] BLANK_WORD = {tce_pkg::BLANK_COLOR, tce_pkg::BLANK_CHAR};

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    cell_addr = AW'(r) * ROW_SPAN + AW'(c);
  endfunction

  tce_pkg::back_state_e state_q, state_d;
  tce_pkg::q_entry_t    cmd_q, cmd_d;
  logic [RW-1:0]        row_q, row_d;
  logic [CW-1:0]        col_q, col_d;
  logic                 hidden_q, hidden_d;
  logic [NW-1:0]        scan_q, scan_d;
  logic                 mv_valid_q, mv_valid_d;
  logic [AW-1:0]        mv_addr_q, mv_addr_d;
  logic [7:0]           rchar_q, rchar_d;
  logic                 report_q, report_d;
  logic                 done_q, done_d;
  tce_pkg::result_t     res_q, res_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [DW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [DW-1:0]        ram_rdata;
  logic [RW-1:0]        w_row;
  logic [CW-1:0]        w_col;
  logic                 is_put;

  tce_ram #(
    .Width (DW),
    .Depth (tce_pkg::CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign is_put = (cmd_q.op == tce_pkg::OP_NEWLINE) || (cmd_q.op == tce_pkg::OP_CR) ||
                  (cmd_q.op == tce_pkg::OP_BS) || (cmd_q.op == tce_pkg::OP_PRINT);

  // No command is taken while the store is being blanked after reset.
  assign hold_o = (state_q == tce_pkg::ST_WIPE) && !report_q;
  assign done_o   = done_q;
  assign result_o = res_q;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    row_d      = row_q;
    col_d      = col_q;
    hidden_d   = hidden_q;
    scan_d     = scan_q;
    mv_valid_d = 1'b0;
    mv_addr_d  = mv_addr_q;
    rchar_d    = rchar_q;
    report_d   = report_q;
    done_d     = 1'b0;
    res_d      = res_q;
    pop_o      = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = BLANK_WORD;
    ram_raddr  = cell_addr(cmd_q.target_row, cmd_q.target_col);
    w_row      = row_q;
    w_col      = col_q;

    unique case (state_q)
      tce_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          cmd_d   = q_entry_i;
          state_d = tce_pkg::ST_EXEC;
        end
      end

      tce_pkg::ST_EXEC: begin
        rchar_d = '0;
        state_d = tce_pkg::ST_FIN;
        unique case (cmd_q.op)
          tce_pkg::OP_NEWLINE: begin
            col_d = '0;
            if (row_q == LAST_ROW) begin
              scan_d  = ROW1_BASE;
              state_d = tce_pkg::ST_SCROLL;
            end else begin
              row_d = row_q + RW'(1);
            end
          end
          tce_pkg::OP_CR: begin
            col_d = '0;
          end
          tce_pkg::OP_BS: begin
            if (col_q == '0) begin
              if (row_q != '0) begin
                w_row  = row_q - RW'(1);
                w_col  = LAST_COL;
                ram_we = 1'b1;
                row_d  = row_q - RW'(1);
                col_d  = LAST_COL;
              end
            end else begin
              w_col  = col_q - CW'(1);
              ram_we = 1'b1;
              col_d  = col_q - CW'(1);
            end
          end
          tce_pkg::OP_PRINT: begin
            ram_we    = 1'b1;
            ram_wdata = {text_color_i, cmd_q.byte_value};
            if (col_q == LAST_COL) begin
              col_d = '0;
              if (row_q == LAST_ROW) begin
                scan_d  = ROW1_BASE;
                state_d = tce_pkg::ST_SCROLL;
              end else begin
                row_d = row_q + RW'(1);
              end
            end else begin
              col_d = col_q + CW'(1);
            end
          end
          tce_pkg::OP_DRAW: begin
            w_row     = cmd_q.target_row;
            w_col     = cmd_q.target_col;
            ram_we    = 1'b1;
            ram_wdata = {cmd_q.cell_color, cmd_q.byte_value};
          end
          tce_pkg::OP_SETCUR: begin
            row_d = cmd_q.target_row;
            col_d = cmd_q.target_col;
          end
          tce_pkg::OP_READ: begin
            state_d = tce_pkg::ST_READ;
          end
          tce_pkg::OP_HIDE: begin
            hidden_d = 1'b1;
          end
          tce_pkg::OP_SHOW: begin
            hidden_d = 1'b0;
          end
          tce_pkg::OP_CLEAR: begin
            row_d    = '0;
            col_d    = '0;
            scan_d   = '0;
            report_d = 1'b1;
            state_d  = tce_pkg::ST_WIPE;
          end
          default: begin
          end
        endcase
      end

      tce_pkg::ST_READ: begin
        rchar_d = ram_rdata[7:0];
        state_d = tce_pkg::ST_FIN;
      end

      // Each cycle reads one cell of rows one onwards and writes the cell read in the
      // previous cycle one row higher.
      tce_pkg::ST_SCROLL: begin
        ram_raddr = scan_q[AW-1:0];
        if (mv_valid_q) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
        end
        if (scan_q < CELL_CNT) begin
          mv_valid_d = 1'b1;
          mv_addr_d  = scan_q[AW-1:0] - ROW_SPAN;
          scan_d     = scan_q + NW'(1);
        end else begin
          scan_d  = LROW_BASE;
          state_d = tce_pkg::ST_BLANK;
        end
      end

      tce_pkg::ST_BLANK: begin
        ram_we = 1'b1;
        scan_d = scan_q + NW'(1);
        if (scan_q == CELL_LAST) begin
          state_d = tce_pkg::ST_FIN;
        end
      end

      tce_pkg::ST_WIPE: begin
        ram_we = 1'b1;
        scan_d = scan_q + NW'(1);
        if (scan_q == CELL_LAST) begin
          report_d = 1'b0;
          state_d  = report_q ? tce_pkg::ST_FIN : tce_pkg::ST_IDLE;
        end
      end

      tce_pkg::ST_FIN: begin
        done_d              = 1'b1;
        res_d.status        = (cmd_q.op == tce_pkg::OP_OOB);
        res_d.read_char     = rchar_q;
        res_d.echo_byte     = is_put ? cmd_q.byte_value : 8'h00;
        res_d.cursor_row    = row_q;
        res_d.cursor_col    = col_q;
        res_d.cursor_hidden = hidden_q;
        res_d.hw_cursor     = HW'(row_q) * HW'(tce_pkg::SCREEN_WIDTH) + HW'(col_q) +
                              (hidden_q ? HW'(tce_pkg::CELLS) : HW'(0));
        state_d             = tce_pkg::ST_IDLE;
      end

      default: begin
        state_d = tce_pkg::ST_IDLE;
      end
    endcase
  end

  // Write address: the moved cell while scrolling, the sweep position while blanking,
  // otherwise the target cell of a draw or the cell at or just before the cursor.
  always_comb begin
    if (state_q == tce_pkg::ST_SCROLL) begin
      ram_waddr = mv_addr_q;
    end else if (state_q == tce_pkg::ST_BLANK || state_q == tce_pkg::ST_WIPE) begin
      ram_waddr = scan_q[AW-1:0];
    end else begin
      ram_waddr = cell_addr(w_row, w_col);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tce_pkg::ST_WIPE;
      row_q      <= '0;
      col_q      <= '0;
      hidden_q   <= 1'b0;
      scan_q     <= '0;
      mv_valid_q <= 1'b0;
      report_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      col_q      <= col_d;
      hidden_q   <= hidden_d;
      scan_q     <= scan_d;
      mv_valid_q <= mv_valid_d;
      report_q   <= report_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    mv_addr_q <= mv_addr_d;
    rchar_q   <= rchar_d;
    res_q     <= res_d;
  end

  // A result word is shown for one cycle and is never followed at once by another.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  // The logical cursor always stays on the screen.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= LAST_ROW) && (col_q <= LAST_COL))
    else $error("cursor left the screen");

  // Every write to the screen store lands inside it.
  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr <= CELL_LAST[AW-1:0]))
    else $error("screen write address out of range");

  // The blanking pass after reset produces no result.
  a_wipe_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_o |-> !done_q)
    else $error("result given during the reset blanking pass");

endmodule

FILE: test/tb.sv
// Self-checking testbench of the text console engine: commands, results and colour register.
`timescale 1ns / 100ps

module tb;
  import tce_pkg::*;

  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam int PHASE_ITEMS = 640;
  // A scroll or a clear gives no result until its sweep of the screen ends; the limit leaves ample margin.
  localparam int STALL_LIMIT = 25000;
  localparam int TAIL_CYCLES = 2100;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start   = 1'b0;
  logic        busy;
  cmd_t        cmd     = '0;
  logic        done_o;
  result_t     result;

  text_console_engine_core u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd),
    .done_o   (done_o),
    .result_o (result)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Predicted screen, cursor and colour register.
  logic [7:0] screen_char [CELLS];
  logic [7:0] screen_attr [CELLS];
  int         crs_row;
  int         crs_col;
  bit         crs_hidden;
  logic [7:0] print_attr;

  cmd_t    cmd_backlog [$];
  result_t result_due  [$];

  int gap_pct;
  int n_accepted, n_results, n_mismatch, n_scrolls, n_clears, n_oob, n_reads, n_colour_writes;
  int stall_cycles;

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) begin
      screen_char[i] = BLANK_CHAR;
      screen_attr[i] = BLANK_COLOR;
    end
  endfunction

  function automatic void set_cell(int r, int c, logic [7:0] ch, logic [7:0] at);
    screen_char[r * SCREEN_WIDTH + c] = ch;
    screen_attr[r * SCREEN_WIDTH + c] = at;
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i + SCREEN_WIDTH < CELLS; i++) begin
      screen_char[i] = screen_char[i + SCREEN_WIDTH];
      screen_attr[i] = screen_attr[i + SCREEN_WIDTH];
    end
    for (int c = 0; c < SCREEN_WIDTH; c++) set_cell(SCREEN_HEIGHT - 1, c, BLANK_CHAR, BLANK_COLOR);
    n_scrolls++;
  endfunction

  function automatic void put_char(logic [7:0] ch);
    case (ch)
      CH_NL: begin
        if (crs_row + 1 >= SCREEN_HEIGHT) scroll_screen();
        else crs_row++;
        crs_col = 0;
      end
      CH_CR: crs_col = 0;
      CH_BS: begin
        // At the home position a backspace has nowhere to go.
        if (crs_col == 0) begin
          if (crs_row != 0) begin
            crs_row--;
            crs_col = SCREEN_WIDTH - 1;
            set_cell(crs_row, crs_col, BLANK_CHAR, BLANK_COLOR);
          end
        end else begin
          crs_col--;
          set_cell(crs_row, crs_col, BLANK_CHAR, BLANK_COLOR);
        end
      end
      default: begin
        set_cell(crs_row, crs_col, ch, print_attr);
        if (crs_col + 1 >= SCREEN_WIDTH) begin
          crs_col = 0;
          if (crs_row + 1 >= SCREEN_HEIGHT) scroll_screen();
          else crs_row++;
        end else begin
          crs_col++;
        end
      end
    endcase
  endfunction

  function automatic result_t console_step(cmd_t c);
    result_t r;
    bit      in_range;
    int      hw;
    r = '0;
    in_range = (c.target_row < SCREEN_HEIGHT) && (c.target_col < SCREEN_WIDTH);
    case (c.action)
      ACT_PUT: begin
        put_char(c.byte_value);
        r.echo_byte = c.byte_value;
      end
      ACT_DRAW: begin
        if (in_range) set_cell(c.target_row, c.target_col, c.byte_value, c.cell_color);
        else r.status = 1'b1;
      end
      ACT_SETCUR: begin
        if (in_range) begin
          crs_row = c.target_row;
          crs_col = c.target_col;
        end else begin
          r.status = 1'b1;
        end
      end
      ACT_READ: begin
        n_reads++;
        if (in_range) r.read_char = screen_char[c.target_row * SCREEN_WIDTH + c.target_col];
        else r.status = 1'b1;
      end
      ACT_HIDE: crs_hidden = 1'b1;
      ACT_SHOW: crs_hidden = 1'b0;
      ACT_CLEAR: begin
        blank_screen();
        crs_row = 0;
        crs_col = 0;
        n_clears++;
      end
      default: ;
    endcase
    if (r.status) n_oob++;
    hw = crs_row * SCREEN_WIDTH + crs_col + (crs_hidden ? CELLS : 0);
    r.cursor_row    = ROW_W'(crs_row);
    r.cursor_col    = COL_W'(crs_col);
    r.cursor_hidden = crs_hidden;
    r.hw_cursor     = HW_W'(hw);
    return r;
  endfunction

  function automatic cmd_t mk_cmd(logic [2:0] act, logic [7:0] bv, int row, int col,
                                  logic [7:0] colr);
    cmd_t c;
    c.action     = act;
    c.byte_value = bv;
    c.target_row = ROW_W'(row);
    c.target_col = COL_W'(col);
    c.cell_color = colr;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   pick;
    int   sub;
    c.byte_value = 8'($urandom_range(255));
    c.cell_color = 8'($urandom_range(255));
    c.target_row = ($urandom_range(99) < 85) ? ROW_W'($urandom_range(SCREEN_HEIGHT - 1))
                                             : ROW_W'($urandom_range(31));
    c.target_col = ($urandom_range(99) < 85) ? COL_W'($urandom_range(SCREEN_WIDTH - 1))
                                             : COL_W'($urandom_range(127));
    pick = $urandom_range(99);
    if (pick < 53) begin
      c.action = ACT_PUT;
      sub = $urandom_range(99);
      // Mostly printable text, with line control mixed in sparingly since scrolls are slow.
      if (sub < 4) c.byte_value = CH_NL;
      else if (sub < 10) c.byte_value = CH_CR;
      else if (sub < 20) c.byte_value = CH_BS;
      else if (sub >= 30) c.byte_value = 8'($urandom_range(8'h7E, 8'h20));
    end else if (pick < 65) c.action = ACT_DRAW;
    else if (pick < 75) c.action = ACT_SETCUR;
    else if (pick < 89) c.action = ACT_READ;
    else if (pick < 92) c.action = ACT_HIDE;
    else if (pick < 95) c.action = ACT_SHOW;
    else if (pick < 96) c.action = ACT_CLEAR;
    else c.action = ACT_UNUSED;
    return c;
  endfunction

  task automatic queue_random(int n);
    int   added;
    cmd_t c;
    added = 0;
    while (added < n) begin
      c = rand_cmd();
      if ($urandom_range(99) < 8) begin
        // Draw a cell and read it straight back.
        c.action = ACT_DRAW;
        cmd_backlog.push_back(c);
        c.action = ACT_READ;
        cmd_backlog.push_back(c);
        added += 2;
      end else begin
        cmd_backlog.push_back(c);
        added++;
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || start || result_due.size() != 0);
  endtask

  task automatic write_text_color(logic [7:0] colr);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(REG_TEXT_COLOR);
    pwdata  <= {24'($urandom_range(32'hFFFFFF)), colr};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    print_attr = colr;
    n_colour_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (prdata[7:0] !== colr) begin
      if (n_mismatch < 10)
        $display("text colour readback: expected %02h, got %02h", colr, prdata[7:0]);
      n_mismatch++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Driver: accept the word on the port, then present the next one or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        result_due.push_back(console_step(cmd));
        n_accepted++;
      end
      if (!start || !busy) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
          cmd   <= cmd_backlog.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      n_results++;
      if (result_due.size() == 0) begin
        if (n_mismatch < 10) $display("result word with no command outstanding: %p", result);
        n_mismatch++;
      end else begin
        want = result_due.pop_front();
        if (result.status !== want.status || result.read_char !== want.read_char ||
            result.echo_byte !== want.echo_byte || result.cursor_row !== want.cursor_row ||
            result.cursor_col !== want.cursor_col ||
            result.cursor_hidden !== want.cursor_hidden ||
            result.hw_cursor !== want.hw_cursor) begin
          if (n_mismatch < 10) begin
            $display("result %0d: expected st=%0d rd=%02h echo=%02h row=%0d col=%0d hid=%0d hw=%0d",
                     n_results, want.status, want.read_char, want.echo_byte, want.cursor_row,
                     want.cursor_col, want.cursor_hidden, want.hw_cursor);
            $display("result %0d: got      st=%0d rd=%02h echo=%02h row=%0d col=%0d hid=%0d hw=%0d",
                     n_results, result.status, result.read_char, result.echo_byte,
                     result.cursor_row, result.cursor_col, result.cursor_hidden,
                     result.hw_cursor);
          end
          n_mismatch++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    gap_pct = 23;
    print_attr = TEXT_COLOR_RST;
    crs_row = 0;
    crs_col = 0;
    crs_hidden = 1'b0;
    blank_screen();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: cursor edges, control characters, bounds and the cursor flag.
    cmd_backlog.push_back(mk_cmd(ACT_READ, 8'h00, 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_PUT, "A", 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_READ, 8'hFF, 0, 0, 8'hFF));
    cmd_backlog.push_back(mk_cmd(ACT_PUT, CH_BS, 31, 127, 8'hFF));
    cmd_backlog.push_back(mk_cmd(ACT_PUT, CH_BS, 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_SETCUR, 8'h00, 0, SCREEN_WIDTH - 1, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_PUT, "x", 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_PUT, CH_BS, 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_PUT, CH_CR, 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_DRAW, 8'hFF, SCREEN_HEIGHT - 1, SCREEN_WIDTH - 1, 8'hFF));
    cmd_backlog.push_back(mk_cmd(ACT_DRAW, 8'h41, SCREEN_HEIGHT, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_DRAW, 8'h42, 31, 127, 8'hFF));
    cmd_backlog.push_back(mk_cmd(ACT_SETCUR, 8'h00, 0, SCREEN_WIDTH, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_READ, 8'h00, SCREEN_HEIGHT - 1, SCREEN_WIDTH, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_READ, 8'h00, SCREEN_HEIGHT, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_SETCUR, 8'h00, SCREEN_HEIGHT - 1, SCREEN_WIDTH - 1, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_PUT, "Z", 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_READ, 8'h00, SCREEN_HEIGHT - 2, SCREEN_WIDTH - 1, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_PUT, CH_NL, 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_SETCUR, 8'h00, 3, 5, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_PUT, CH_NL, 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_HIDE, 8'h00, 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_HIDE, 8'h00, 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_PUT, 8'h00, 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_PUT, 8'hFF, 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_UNUSED, 8'hFF, 31, 127, 8'hFF));
    cmd_backlog.push_back(mk_cmd(ACT_CLEAR, 8'h00, 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_READ, 8'h00, 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_SHOW, 8'h00, 0, 0, 8'h00));
    cmd_backlog.push_back(mk_cmd(ACT_SHOW, 8'h00, 0, 0, 8'h00));
    drain();

    write_text_color(8'h00);
    queue_random(PHASE_ITEMS);
    drain();

    gap_pct = 64;
    write_text_color(8'hFF);
    queue_random(PHASE_ITEMS);
    drain();

    gap_pct = 0;
    write_text_color(8'($urandom_range(254, 1)));
    queue_random(PHASE_ITEMS);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (result_due.size() != 0) begin
      $display("%0d predicted results never arrived", result_due.size());
      n_mismatch++;
    end
    $display("Ran %0d commands and checked %0d results under %0d text colour settings.",
             n_accepted, n_results, n_colour_writes + 1);
    $display("Included %0d scrolls, %0d clears, %0d cell reads, %0d out-of-range accesses.",
             n_scrolls, n_clears, n_reads, n_oob);
    if (n_mismatch == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: text_console_engine_core.f
rtl/core/tce_pkg.sv
rtl/core/tce_ram.sv
rtl/core/tce_front.sv
rtl/core/tce_back.sv
rtl/core/text_console_engine_core.sv
test/tb.sv
